[sv/vb128_pkg.sv]
// shared types, status codes and helpers for the base-128 varint decoder
package vb128_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned USED_W  = 4;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // group index of the ninth byte, the one that carries a full eight bits
  localparam logic [IDX_W-1:0] LAST_GROUP = 4'd8;

  // byte address of the signed_mode register
  localparam logic [ADDR_W-1:0] REG_SIGNED_MODE = 3'd0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  typedef struct packed {
    logic                emit;
    logic [VALUE_W-1:0]  value;
    status_t             status;
    logic [USED_W-1:0]   used;
    logic [VALUE_W-1:0]  acc_nxt;
    logic [IDX_W-1:0]    idx_nxt;
  } step_t;

  function automatic logic [VALUE_W-1:0] zigzag_back(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] w;
    w = v >> 1;
    if (v[0]) begin
      w = ~w;
    end
    return w;
  endfunction

endpackage

[sv/varint_base128_strict_decoder.sv]
// top level: strict base-128 varint decoder with input and result registers
// bytes are held in the input register, results in the result register
// throughput: one byte per cycle while out_stall does not hold a result;
// the accumulate step between the input and result registers sets it
// reset: synchronous active-low rst_n clears valid flags, accumulator,
// group index and signed_mode; no clearing pass
module varint_base128_strict_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte_value,
  input  logic                               in_buffer_end,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_decoded_value,
  output logic [1:0]                         out_status,
  output logic [3:0]                         out_bytes_used,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vb128_pkg::ADDR_W-1:0]       paddr,
  input  logic [vb128_pkg::DATA_W-1:0]       pwdata,
  output logic [vb128_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  logic                            s1_valid_r;
  logic [7:0]                      s1_byte_r;
  logic                            s1_end_r;
  logic                            s1_adv;
  logic                            in_take;
  logic [vb128_pkg::VALUE_W-1:0]   acc_r;
  logic [vb128_pkg::IDX_W-1:0]     idx_r;
  logic                            signed_mode_r;
  logic                            out_valid_r;
  logic [vb128_pkg::VALUE_W-1:0]   out_value_r;
  vb128_pkg::status_t              out_status_r;
  logic [vb128_pkg::USED_W-1:0]    out_used_r;
  logic                            out_free;
  vb128_pkg::step_t                step;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  vb128_step u_step (
    .byte_value  (s1_byte_r),
    .buffer_end  (s1_end_r),
    .acc         (acc_r),
    .idx         (idx_r),
    .signed_mode (signed_mode_r),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte_value;
      s1_end_r  <= in_buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else if (s1_adv) begin
      acc_r <= step.acc_nxt;
      idx_r <= step.idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step.emit) begin
      out_value_r  <= step.value;
      out_status_r <= step.status;
      out_used_r   <= step.used;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == vb128_pkg::REG_SIGNED_MODE[2]) begin
      signed_mode_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vb128_pkg::REG_SIGNED_MODE[2]) ?
                  {31'd0, signed_mode_r} : '0;

  assign out_valid         = out_valid_r;
  assign out_decoded_value = out_value_r;
  assign out_status        = out_status_r;
  assign out_bytes_used    = out_used_r;

endmodule

[sv/vb128_step.sv]
// one decode step: folds a byte or end marker into the accumulator state
module vb128_step (
  input  logic [7:0]                      byte_value,
  input  logic                            buffer_end,
  input  logic [vb128_pkg::VALUE_W-1:0]   acc,
  input  logic [vb128_pkg::IDX_W-1:0]     idx,
  input  logic                            signed_mode,
  output vb128_pkg::step_t                step
);

  logic [vb128_pkg::IDX_W-1:0]   sel;
  logic [5:0]                    shamt;
  logic [vb128_pkg::VALUE_W-1:0] acc_or;
  logic [vb128_pkg::VALUE_W-1:0] acc_last;
  logic                          byte_zero;

  assign sel       = (idx > vb128_pkg::LAST_GROUP) ? vb128_pkg::LAST_GROUP : idx;
  assign shamt     = 6'(sel[2:0]) * 6'd7;
  assign acc_or    = acc | ({57'd0, byte_value[6:0]} << shamt);
  assign acc_last  = acc | {byte_value, 56'd0};
  assign byte_zero = (byte_value == 8'd0);

  always_comb begin
    step.emit    = 1'b0;
    step.value   = '0;
    step.status  = vb128_pkg::ST_OK;
    step.used    = '0;
    step.acc_nxt = acc;
    step.idx_nxt = idx;
    if (buffer_end) begin
      if (sel != '0) begin
        step.emit   = 1'b1;
        step.status = vb128_pkg::ST_TRUNC;
        step.used   = sel;
      end
    end else if (sel < vb128_pkg::LAST_GROUP) begin
      if (byte_zero && sel != '0) begin
        step.emit   = 1'b1;
        step.status = vb128_pkg::ST_ZERO;
        step.used   = sel + 4'd1;
      end else if (!byte_value[7]) begin
        step.emit  = 1'b1;
        step.value = acc_or;
        step.used  = sel + 4'd1;
      end else begin
        step.acc_nxt = acc_or;
        step.idx_nxt = sel + 4'd1;
      end
    end else begin
      step.emit = 1'b1;
      step.used = 4'd9;
      if (byte_zero) begin
        step.status = vb128_pkg::ST_ZERO;
      end else begin
        step.value = acc_last;
      end
    end
    if (step.emit) begin
      step.acc_nxt = '0;
      step.idx_nxt = '0;
      if (step.status == vb128_pkg::ST_OK && signed_mode) begin
        step.value = vb128_pkg::zigzag_back(step.value);
      end
    end
  end

endmodule

[sv/vb128_chk.sv]
// port-level checker for the varint decoder, bound to the top level
module vb128_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_decoded_value,
  input logic [1:0]  out_status,
  input logic [3:0]  out_bytes_used
);

  // failed decodes carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vb128_pkg::ST_OK |-> out_decoded_value == 64'd0)
    else $error("error result with nonzero value");

  // truncation only after at least one byte, never after nine
  a_trunc_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vb128_pkg::ST_TRUNC |->
      out_bytes_used != 4'd0 && out_bytes_used <= 4'd8)
    else $error("truncation with bad byte count");

  // a zero group is rejected only from the second byte on
  a_zero_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == vb128_pkg::ST_ZERO |->
      out_bytes_used >= 4'd2 && out_bytes_used <= 4'd9)
    else $error("zero-group reject with bad byte count");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == vb128_pkg::ST_OK || out_status == vb128_pkg::ST_ZERO ||
      out_status == vb128_pkg::ST_TRUNC)
    else $error("undefined status code");

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_decoded_value) &&
      $stable(out_status) && $stable(out_bytes_used))
    else $error("stalled result changed");

endmodule

bind varint_base128_strict_decoder vb128_chk u_vb128_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_decoded_value (out_decoded_value),
  .out_status        (out_status),
  .out_bytes_used    (out_bytes_used)
);
